/* design/atlv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package atlv_pkg;

    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int SIZE_OUT_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_CODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_CODE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_CODE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_TYPE_CODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NAME_TYPE_CODE = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_DATA_CODE      = 8'd1;
    localparam logic [CFG_DATA_W-1:0] RST_START_CODE     = 8'd2;
    localparam logic [CFG_DATA_W-1:0] RST_END_CODE       = 8'd3;
    localparam logic [CFG_DATA_W-1:0] RST_SIZE_TYPE_CODE = 8'd0;
    localparam logic [CFG_DATA_W-1:0] RST_NAME_TYPE_CODE = 8'd1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_SEQ  = 4'd1,
        PH_LHI  = 4'd2,
        PH_LLO  = 4'd3,
        PH_PAY  = 4'd4,
        PH_T1   = 4'd5,
        PH_SLEN = 4'd6,
        PH_SVAL = 4'd7,
        PH_T2   = 4'd8,
        PH_NLEN = 4'd9,
        PH_NAME = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_NAME     = 3'd1,
        KIND_DATA_HDR = 3'd2,
        KIND_CTRL_HDR = 3'd3,
        KIND_ERROR    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_CONTROL   = 2'd1,
        ERR_SIZE_TYPE = 2'd2,
        ERR_NAME_TYPE = 2'd3
    } t_err;

    // Compact result word: data holds the byte for payload and name words
    // and the sequence number for a data header.
    typedef struct packed {
        t_kind                 kind;
        logic [BYTE_W-1:0]     data;
        logic [LEN_W-1:0]      len;
        logic [SIZE_OUT_W-1:0] size;
        logic                  is_end;
        t_err                  err;
        logic                  last;
    } t_entry;

endpackage

`default_nettype wire

/* design/atlv_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module atlv_front
    import atlv_pkg::*;
#(
    parameter int SIZE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [BYTE_W-1:0]      i_packet_byte,
    input  wire logic                   i_first,
    input  wire logic                   i_full,
    output logic                        o_push,
    output t_entry                      o_entry
);

    localparam int EXT_W = (SIZE_WIDTH > SIZE_OUT_W) ? SIZE_WIDTH : SIZE_OUT_W;

    logic [CFG_DATA_W-1:0] r_data_code;
    logic [CFG_DATA_W-1:0] r_start_code;
    logic [CFG_DATA_W-1:0] r_end_code;
    logic [CFG_DATA_W-1:0] r_size_type_code;
    logic [CFG_DATA_W-1:0] r_name_type_code;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [LEN_W-1:0]      r_bytes_left;
    logic [LEN_W-1:0]      n_bytes_left;
    logic [BYTE_W-1:0]     r_seq;
    logic [BYTE_W-1:0]     n_seq;
    logic [BYTE_W-1:0]     r_len_hi;
    logic [BYTE_W-1:0]     n_len_hi;
    logic [SIZE_WIDTH-1:0] r_size_acc;
    logic [SIZE_WIDTH-1:0] n_size_acc;
    logic                  r_end_flag;
    logic                  n_end_flag;

    logic                  w_acc;
    logic                  w_is_data;
    logic                  w_is_ctrl;
    logic                  w_left_one;
    logic [LEN_W-1:0]      w_data_len;
    logic [EXT_W-1:0]      w_size_ext;

    assign o_ready    = !i_full;
    assign w_acc      = i_valid && o_ready;
    assign w_is_data  = (i_packet_byte == r_data_code);
    assign w_is_ctrl  = (i_packet_byte == r_start_code) || (i_packet_byte == r_end_code);
    assign w_left_one = (r_bytes_left == LEN_W'(1));
    assign w_data_len = {r_len_hi, i_packet_byte};
    assign w_size_ext = EXT_W'(r_size_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_code      <= RST_DATA_CODE;
            r_start_code     <= RST_START_CODE;
            r_end_code       <= RST_END_CODE;
            r_size_type_code <= RST_SIZE_TYPE_CODE;
            r_name_type_code <= RST_NAME_TYPE_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DATA_CODE:      r_data_code      <= i_cfg_data;
                CFG_START_CODE:     r_start_code     <= i_cfg_data;
                CFG_END_CODE:       r_end_code       <= i_cfg_data;
                CFG_SIZE_TYPE_CODE: r_size_type_code <= i_cfg_data;
                CFG_NAME_TYPE_CODE: r_name_type_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (w_acc) begin
            if (i_first) begin
                priority if (w_is_data) begin
                    n_phase = PH_SEQ;
                end else if (w_is_ctrl) begin
                    n_phase = PH_T1;
                end else begin
                    n_phase = PH_IDLE;
                end
            end else begin
                unique case (r_phase)
                    PH_SEQ:  n_phase = PH_LHI;
                    PH_LHI:  n_phase = PH_LLO;
                    PH_LLO:  n_phase = (w_data_len == '0) ? PH_IDLE : PH_PAY;
                    PH_PAY:  n_phase = w_left_one ? PH_IDLE : PH_PAY;
                    PH_T1:   n_phase = (i_packet_byte == r_size_type_code) ? PH_SLEN : PH_IDLE;
                    PH_SLEN: n_phase = (i_packet_byte == '0) ? PH_T2 : PH_SVAL;
                    PH_SVAL: n_phase = w_left_one ? PH_T2 : PH_SVAL;
                    PH_T2:   n_phase = (i_packet_byte == r_name_type_code) ? PH_NLEN : PH_IDLE;
                    PH_NLEN: n_phase = (i_packet_byte == '0) ? PH_IDLE : PH_NAME;
                    PH_NAME: n_phase = w_left_one ? PH_IDLE : PH_NAME;
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        o_push         = 1'b0;
        o_entry        = '0;
        o_entry.kind   = KIND_PAYLOAD;
        o_entry.err    = ERR_NONE;
        o_entry.data   = i_packet_byte;
        o_entry.size   = w_size_ext[SIZE_OUT_W-1:0];
        o_entry.is_end = r_end_flag;
        if (w_acc) begin
            if (i_first) begin
                if (!w_is_data && !w_is_ctrl) begin
                    o_push       = 1'b1;
                    o_entry.kind = KIND_ERROR;
                    o_entry.err  = ERR_CONTROL;
                    o_entry.last = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_LLO: begin
                        o_push       = 1'b1;
                        o_entry.kind = KIND_DATA_HDR;
                        o_entry.data = r_seq;
                        o_entry.len  = w_data_len;
                        o_entry.last = (w_data_len == '0);
                    end
                    PH_PAY: begin
                        o_push       = 1'b1;
                        o_entry.kind = KIND_PAYLOAD;
                        o_entry.last = w_left_one;
                    end
                    PH_T1: begin
                        if (i_packet_byte != r_size_type_code) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_ERROR;
                            o_entry.err  = ERR_SIZE_TYPE;
                            o_entry.last = 1'b1;
                        end
                    end
                    PH_T2: begin
                        if (i_packet_byte != r_name_type_code) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_ERROR;
                            o_entry.err  = ERR_NAME_TYPE;
                            o_entry.last = 1'b1;
                        end
                    end
                    PH_NLEN: begin
                        o_push       = 1'b1;
                        o_entry.kind = KIND_CTRL_HDR;
                        o_entry.len  = LEN_W'(i_packet_byte);
                        o_entry.last = (i_packet_byte == '0);
                    end
                    PH_NAME: begin
                        o_push       = 1'b1;
                        o_entry.kind = KIND_NAME;
                        o_entry.last = w_left_one;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_seq        = r_seq;
        n_len_hi     = r_len_hi;
        n_size_acc   = r_size_acc;
        n_end_flag   = r_end_flag;
        if (w_acc) begin
            if (i_first) begin
                n_bytes_left = '0;
                n_seq        = '0;
                n_len_hi     = '0;
                n_size_acc   = '0;
                n_end_flag   = !w_is_data && w_is_ctrl && (i_packet_byte != r_start_code);
            end else begin
                unique case (r_phase)
                    PH_SEQ:  n_seq = i_packet_byte;
                    PH_LHI:  n_len_hi = i_packet_byte;
                    PH_LLO:  n_bytes_left = w_data_len;
                    PH_SLEN: begin
                        n_bytes_left = LEN_W'(i_packet_byte);
                        n_size_acc   = '0;
                    end
                    PH_SVAL: begin
                        n_size_acc   = SIZE_WIDTH'({r_size_acc, i_packet_byte});
                        n_bytes_left = r_bytes_left - LEN_W'(1);
                    end
                    PH_NLEN: n_bytes_left = LEN_W'(i_packet_byte);
                    PH_PAY, PH_NAME: n_bytes_left = r_bytes_left - LEN_W'(1);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= '0;
            r_seq        <= '0;
            r_len_hi     <= '0;
            r_size_acc   <= '0;
            r_end_flag   <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_seq        <= n_seq;
            r_len_hi     <= n_len_hi;
            r_size_acc   <= n_size_acc;
            r_end_flag   <= n_end_flag;
        end
    end

    // Every error word closes its packet and returns the parser to idle.
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.kind == KIND_ERROR) |-> (o_entry.last && n_phase == PH_IDLE))
        else $error("error word without last or without return to idle");

    // A word marked last always leaves the parser idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.last) |=> (r_phase == PH_IDLE))
        else $error("parser not idle after the last word of a packet");

    // Payload, size-value and name phases always have bytes left to count.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY || r_phase == PH_NAME || r_phase == PH_SVAL)
            |-> (r_bytes_left != '0))
        else $error("byte counter empty inside a counted field");

endmodule

`default_nettype wire

/* design/atlv_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module atlv_fifo
    import atlv_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    output logic        o_valid,
    input  wire logic   i_pop,
    output t_entry      o_entry
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("word popped from an empty queue");

endmodule

`default_nettype wire

/* design/atlv_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module atlv_back
    import atlv_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_fifo_valid,
    input  wire t_entry                 i_entry,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [2:0]                  o_result_kind,
    output logic [BYTE_W-1:0]           o_value,
    output logic [BYTE_W-1:0]           o_sequence_res,
    output logic [LEN_W-1:0]            o_field_length,
    output logic [SIZE_OUT_W-1:0]       o_file_size,
    output logic                        o_is_end,
    output logic [1:0]                  o_error_code,
    output logic                        o_last
);

    logic   r_valid;
    t_entry r_entry;

    assign o_pop   = i_fifo_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

    // Fields that do not belong to a word's kind read as zero.
    always_comb begin
        o_result_kind  = r_entry.kind;
        o_value        = '0;
        o_sequence_res = '0;
        o_field_length = '0;
        o_file_size    = '0;
        o_is_end       = 1'b0;
        o_error_code   = ERR_NONE;
        o_last         = r_entry.last;
        unique case (r_entry.kind)
            KIND_PAYLOAD, KIND_NAME: begin
                o_value = r_entry.data;
            end
            KIND_DATA_HDR: begin
                o_sequence_res = r_entry.data;
                o_field_length = r_entry.len;
            end
            KIND_CTRL_HDR: begin
                o_field_length = r_entry.len;
                o_file_size    = r_entry.size;
                o_is_end       = r_entry.is_end;
            end
            KIND_ERROR: begin
                o_error_code = r_entry.err;
            end
            default: ;
        endcase
    end

    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_entry.kind == KIND_ERROR) |-> (r_entry.err != ERR_NONE && r_entry.last))
        else $error("error word without code or without last");

    a_pop_refills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("output register empty after a pop");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !o_pop)
        else $error("queue popped while the output word is stalled");

endmodule

`default_nettype wire

/* design/app_packet_tlv_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial parser for data packets and start/end control packets in
// type-length-value form. One byte is accepted per clock cycle whenever the
// result queue has room, so with o_ready held by a consumer that keeps
// i_ready high the block sustains one byte per cycle. Each accepted byte
// gives at most one result word; the word is written into a QUEUE_DEPTH-entry
// queue at the edge that accepts its byte and then moves into an output
// register, and the queue absorbs up to QUEUE_DEPTH words while the output
// is stalled. A byte with i_first high starts a new
// packet from any phase; bytes outside a packet are dropped. The file size
// is accumulated over SIZE_WIDTH bits and reported as its low 32 bits.
// Configuration writes take effect on the next cycle.

module app_packet_tlv_parser
    import atlv_pkg::*;
#(
    parameter int SIZE_WIDTH  = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [7:0]             i_packet_byte,
    input  wire logic                   i_first,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [2:0]                  o_result_kind,
    output logic [7:0]                  o_value,
    output logic [7:0]                  o_sequence_res,
    output logic [15:0]                 o_field_length,
    output logic [31:0]                 o_file_size,
    output logic                        o_is_end,
    output logic [1:0]                  o_error_code,
    output logic                        o_last
);

    logic   w_push;
    t_entry w_push_entry;
    logic   w_full;
    logic   w_fifo_valid;
    logic   w_pop;
    t_entry w_head_entry;

    atlv_front #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_packet_byte (i_packet_byte),
        .i_first       (i_first),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    atlv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_fifo_valid),
        .i_pop   (w_pop),
        .o_entry (w_head_entry)
    );

    atlv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fifo_valid   (w_fifo_valid),
        .i_entry        (w_head_entry),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_value        (o_value),
        .o_sequence_res (o_sequence_res),
        .o_field_length (o_field_length),
        .o_file_size    (o_file_size),
        .o_is_end       (o_is_end),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
